[rtl/text_terminal_writer_top_macros.svh]
// ----------------------------------------------------------------------------
// Text terminal writer assertion macros
// Shared property macros for the text terminal writer design.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_WRITER_TOP_MACROS_SVH
`define TEXT_TERMINAL_WRITER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define TTW_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);
`define TTW_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);
`else
`define TTW_ASSERT_NOW(label, clk, rst, cond, conseq, msg)
`define TTW_ASSERT_NEXT(label, clk, rst, cond, conseq, msg)
`endif

`endif

[rtl/ttw_pkg.sv]
// ----------------------------------------------------------------------------
// Text terminal writer package
// Types and fixed constants shared by the terminal writer modules.
// ----------------------------------------------------------------------------
package ttw_pkg;

   localparam logic       OP_PUT       = 1'b0;
   localparam logic       OP_READ      = 1'b1;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] RESET_COLOR  = 8'h03;

   typedef enum logic [1:0] {
      KIND_PUT,
      KIND_NEWLINE,
      KIND_READ,
      KIND_NULL
   } ttw_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_FILL,
      ST_COPY,
      ST_BLANK,
      ST_DONE
   } ttw_state_type;

   typedef struct packed {
      ttw_kind_type kind;
      logic [7:0]   char_code;
      logic [7:0]   char_color;
      logic [4:0]   cell_row;
      logic [6:0]   cell_col;
   } ttw_cmd_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic [7:0] read_color;
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
      logic       scrolled;
   } ttw_rsp_type;

endpackage

[rtl/ttw_fifo.sv]
// ----------------------------------------------------------------------------
// Text terminal writer queue
// Small register queue used between the front, the back and the result port.
// ----------------------------------------------------------------------------
module ttw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/ttw_front.sv]
// ----------------------------------------------------------------------------
// Text terminal writer front end
// Accepts items and sorts them into put, newline, read and empty read commands.
// ----------------------------------------------------------------------------
module ttw_front #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic               push,
   output logic               full,
   input  logic               req_opcode,
   input  logic [7:0]         req_char_code,
   input  logic [7:0]         req_char_color,
   input  logic [4:0]         req_cell_row,
   input  logic [6:0]         req_cell_col,
   input  logic               clear_busy,
   input  logic               cmd_full,
   output logic               cmd_push,
   output ttw_pkg::ttw_cmd_type cmd
);

   import ttw_pkg::*;

   logic in_range;

   assign in_range = (32'(req_cell_row) < SCREEN_ROWS) && (32'(req_cell_col) < SCREEN_COLS);
   assign full     = cmd_full || clear_busy;
   assign cmd_push = push && !full;

   always_comb begin
      cmd.char_code  = req_char_code;
      cmd.char_color = req_char_color;
      cmd.cell_row   = req_cell_row;
      cmd.cell_col   = req_cell_col;
      if (req_opcode == OP_READ) begin
         cmd.kind = in_range ? KIND_READ : KIND_NULL;
      end else begin
         cmd.kind = (req_char_code == NEWLINE_CHAR) ? KIND_NEWLINE : KIND_PUT;
      end
   end

endmodule

[rtl/ttw_back.sv]
// ----------------------------------------------------------------------------
// Text terminal writer back end
// Owns the cell memory and cursor and carries out one command at a time.
// ----------------------------------------------------------------------------
module ttw_back #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [7:0]           csr_wdata,
   input  logic                 cmd_empty,
   input  ttw_pkg::ttw_cmd_type cmd,
   output logic                 cmd_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output ttw_pkg::ttw_rsp_type rsp,
   output logic                 clear_busy
);

   import ttw_pkg::*;

   localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(SCREEN_COLS);
   localparam int ROW_W  = $clog2(SCREEN_ROWS);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'(CELLS - SCREEN_COLS);
   localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'(CELLS - SCREEN_COLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(SCREEN_COLS);
   localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(SCREEN_ROWS - 1);

   logic [15:0]        mem [CELLS];
   logic [15:0]        rdata_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [15:0]        mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ADDR_W-1:0]  read_addr;

   ttw_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ADDR_W-1:0]  cur_addr_ff, cur_addr_in;
   logic               wr_pending_ff, wr_pending_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [7:0]         blank_color_ff;
   logic [7:0]         fill_color_ff, fill_color_in;
   logic [7:0]         rd_char_ff, rd_char_in;
   logic [7:0]         rd_color_ff, rd_color_in;
   logic               scrolled_ff, scrolled_in;
   logic               at_bottom;

   assign read_addr  = ADDR_W'(ADDR_W'(cmd.cell_row) * ROW_STRIDE) + ADDR_W'(cmd.cell_col);
   assign at_bottom  = (cur_row_ff == ROW_LAST);
   assign clear_busy = (state_ff == ST_CLEAR);

   assign rsp.read_char  = rd_char_ff;
   assign rsp.read_color = rd_color_ff;
   assign rsp.cursor_row = 5'(cur_row_ff);
   assign rsp.cursor_col = 7'(cur_col_ff);
   assign rsp.scrolled   = scrolled_ff;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      cur_addr_in   = cur_addr_ff;
      wr_pending_in = 1'b0;
      wr_addr_in    = ptr_ff;
      fill_color_in = fill_color_ff;
      rd_char_in    = rd_char_ff;
      rd_color_in   = rd_color_ff;
      scrolled_in   = scrolled_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      mem_raddr     = read_addr;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = {RESET_COLOR, SPACE_CHAR};

      if (wr_pending_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr_ff;
         mem_wdata = rdata_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = {RESET_COLOR, SPACE_CHAR};
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop     = 1'b1;
               rd_char_in  = '0;
               rd_color_in = '0;
               scrolled_in = 1'b0;
               case (cmd.kind)
                  KIND_READ: begin
                     state_in = ST_READ;
                  end
                  KIND_NULL: begin
                     state_in = ST_DONE;
                  end
                  KIND_NEWLINE: begin
                     fill_color_in = cmd.char_color;
                     state_in      = ST_FILL;
                  end
                  KIND_PUT: begin
                     mem_we    = 1'b1;
                     mem_waddr = cur_addr_ff;
                     mem_wdata = {cmd.char_color, cmd.char_code};
                     if (cur_col_ff == COL_LAST) begin
                        cur_col_in = '0;
                        if (at_bottom) begin
                           cur_addr_in = BOTTOM_ADDR;
                           scrolled_in = 1'b1;
                           ptr_in      = '0;
                           state_in    = ST_COPY;
                        end else begin
                           cur_row_in  = cur_row_ff + 1'b1;
                           cur_addr_in = cur_addr_ff + 1'b1;
                           state_in    = ST_DONE;
                        end
                     end else begin
                        cur_col_in  = cur_col_ff + 1'b1;
                        cur_addr_in = cur_addr_ff + 1'b1;
                        state_in    = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_char_in  = rdata_ff[7:0];
            rd_color_in = rdata_ff[15:8];
            state_in    = ST_DONE;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr_ff;
            mem_wdata = {fill_color_ff, SPACE_CHAR};
            if (cur_col_ff == COL_LAST) begin
               cur_col_in = '0;
               if (at_bottom) begin
                  cur_addr_in = BOTTOM_ADDR;
                  scrolled_in = 1'b1;
                  ptr_in      = '0;
                  state_in    = ST_COPY;
               end else begin
                  cur_row_in  = cur_row_ff + 1'b1;
                  cur_addr_in = cur_addr_ff + 1'b1;
                  state_in    = ST_DONE;
               end
            end else begin
               cur_col_in  = cur_col_ff + 1'b1;
               cur_addr_in = cur_addr_ff + 1'b1;
            end
         end
         ST_COPY: begin
            mem_raddr     = ptr_ff + ROW_STRIDE;
            wr_pending_in = 1'b1;
            wr_addr_in    = ptr_ff;
            if (ptr_ff == COPY_LAST) begin
               ptr_in   = BOTTOM_ADDR;
               state_in = ST_BLANK;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_BLANK: begin
            if (!wr_pending_ff) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff;
               mem_wdata = {blank_color_ff, SPACE_CHAR};
               if (ptr_ff == LAST_ADDR) begin
                  ptr_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         ptr_ff         <= '0;
         cur_row_ff     <= '0;
         cur_col_ff     <= '0;
         cur_addr_ff    <= '0;
         wr_pending_ff  <= 1'b0;
         blank_color_ff <= RESET_COLOR;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         cur_addr_ff   <= cur_addr_in;
         wr_pending_ff <= wr_pending_in;
         if (csr_we) begin
            blank_color_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff    <= wr_addr_in;
      fill_color_ff <= fill_color_in;
      rd_char_ff    <= rd_char_in;
      rd_color_ff   <= rd_color_in;
      scrolled_ff   <= scrolled_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

endmodule

[rtl/text_terminal_writer_top.sv]
// ----------------------------------------------------------------------------
// Text terminal writer
// Character terminal with a cell memory, cursor, newline fill and scrolling.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Content
//   req_      in         push / full    opcode, character, color, read cell
//   rsp_      out        empty / pop    read cell, cursor, scroll flag
//   csr_      in         csr_we         blank color byte
//
// The back end carries out one command at a time. A newline fills the cursor
// cell and the rest of its row with blanks, one cell written per cycle. A
// scroll adds the row copy and the bottom row clear. After reset a clearing
// pass over all SCREEN_COLS * SCREEN_ROWS cells (2000 by default) holds full
// high. Two-entry queues sit between the front end, the back end and the
// result port.
//
`include "text_terminal_writer_top_macros.svh"

module text_terminal_writer_top #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_opcode,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_char_color,
   input  logic [4:0] req_cell_row,
   input  logic [6:0] req_cell_col,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_read_char,
   output logic [7:0] rsp_read_color,
   output logic [4:0] rsp_cursor_row,
   output logic [6:0] rsp_cursor_col,
   output logic       rsp_scrolled,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   import ttw_pkg::*;

   ttw_cmd_type cmd_in;
   ttw_cmd_type cmd_out;
   logic        cmd_push;
   logic        cmd_full;
   logic        cmd_pop;
   logic        cmd_empty;
   ttw_rsp_type rsp_in;
   ttw_rsp_type rsp_out;
   logic        rsp_push;
   logic        rsp_full;
   logic        clear_busy;

   ttw_front #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS)
   ) u_front (
      .push          (push),
      .full          (full),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .req_char_color(req_char_color),
      .req_cell_row  (req_cell_row),
      .req_cell_col  (req_cell_col),
      .clear_busy    (clear_busy),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd           (cmd_in)
   );

   ttw_fifo #(
      .WIDTH($bits(ttw_cmd_type)),
      .DEPTH(2)
   ) u_cmd_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_data(cmd_in),
      .full   (cmd_full),
      .pop    (cmd_pop),
      .rd_data(cmd_out),
      .empty  (cmd_empty)
   );

   ttw_back #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in),
      .clear_busy(clear_busy)
   );

   ttw_fifo #(
      .WIDTH($bits(ttw_rsp_type)),
      .DEPTH(2)
   ) u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(rsp_in),
      .full   (rsp_full),
      .pop    (pop),
      .rd_data(rsp_out),
      .empty  (empty)
   );

   assign rsp_read_char  = rsp_out.read_char;
   assign rsp_read_color = rsp_out.read_color;
   assign rsp_cursor_row = rsp_out.cursor_row;
   assign rsp_cursor_col = rsp_out.cursor_col;
   assign rsp_scrolled   = rsp_out.scrolled;

   `TTW_ASSERT_NOW(a_no_push_while_clearing, clock, reset, cmd_push, !clear_busy, "item taken during clear")
   `TTW_ASSERT_NOW(a_rsp_never_overflows, clock, reset, rsp_push, !rsp_full, "result queue overflow")
   `TTW_ASSERT_NOW(a_cursor_col_in_range, clock, reset, !empty, 32'(rsp_cursor_col) < SCREEN_COLS, "cursor column out of range")
   `TTW_ASSERT_NOW(a_scroll_at_row_start, clock, reset, !empty && rsp_scrolled, rsp_cursor_col == '0, "scroll left cursor off row start")
   `TTW_ASSERT_NEXT(a_clear_blocks_input, clock, reset, $past(reset), full, "input open right after reset")

endmodule
